### hw/rtl/tanh_activation_unit_top_defines.svh
// Assertion helpers for the tanh activation unit.
// Both expect clk and rst_n in the scope where they are used.
`ifndef TANH_ACTIVATION_UNIT_TOP_DEFINES_SVH
`define TANH_ACTIVATION_UNIT_TOP_DEFINES_SVH

// Same-cycle implication
`define TAU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tau: same-cycle check failed");

// Next-cycle implication
`define TAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tau: next-cycle check failed");

`endif

### hw/rtl/tau_pkg.sv
package tau_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int MAG_W         = 16;
  localparam int FRAC_W        = 62;              // Q0.62 internal format
  localparam int E_W           = FRAC_W + 1;      // holds 1.0 exactly
  localparam int PROD_W        = 2 * E_W;
  localparam int HALF_W        = 32;
  localparam int EXP_STEPS     = MAG_W;           // one step per magnitude bit
  localparam int Q_W           = FRAC_W;          // quotient bits
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = Q_W / DIV_PER_STAGE;
  localparam int R_W           = E_W + 1;         // remainder / divisor width
  localparam int ROUND_POS     = FRAC_W - 14;     // Q62 to Q14
  localparam int RESULT_W      = E_W - ROUND_POS + 1;

  localparam logic [E_W-1:0] Q62_ONE = E_W'(1) << FRAC_W;
  localparam logic [E_W-1:0] ROUND_BIAS = E_W'(1) << (ROUND_POS - 1);
  localparam logic signed [RESULT_W-1:0] RESULT_MAX = RESULT_W'(16384);

  typedef logic [E_W-1:0] tau_fix_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } tau_side_t;

  typedef logic [EXP_STEPS-1:0][E_W-1:0] tau_base_tab_t;

  // (a*b) >> 62, truncated; elaboration use only
  function automatic tau_fix_t mul_q62_f(tau_fix_t a, tau_fix_t b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod[FRAC_W+E_W-1:FRAC_W];
  endfunction

  // exp(-1/2048) by six Taylor terms
  function automatic tau_fix_t exp_base_f();
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << FRAC_W;
    sum  = term;
    term = (term >> 11) / 64'd1;
    sum  = sum - term;
    term = (term >> 11) / 64'd2;
    sum  = sum + term;
    term = (term >> 11) / 64'd3;
    sum  = sum - term;
    term = (term >> 11) / 64'd4;
    sum  = sum + term;
    term = (term >> 11) / 64'd5;
    sum  = sum - term;
    term = (term >> 11) / 64'd6;
    sum  = sum + term;
    return sum[E_W-1:0];
  endfunction

  // exp(-2^k/2048) by repeated truncated squaring
  function automatic tau_base_tab_t base_tab_f();
    tau_base_tab_t tab;
    tab[0] = exp_base_f();
    for (int k = 1; k < EXP_STEPS; k++) begin
      tab[k] = mul_q62_f(tab[k-1], tab[k-1]);
    end
    return tab;
  endfunction

  localparam tau_base_tab_t BASE_TAB = base_tab_f();

endpackage

### hw/rtl/tau_mul.sv
// Two-stage (a*b) >> 62 on Q0.62 operands: partial products, then sum.
module tau_mul import tau_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  tau_fix_t a_i,
  input  tau_fix_t b_i,
  output tau_fix_t p_o
);

  localparam int HI_W = E_W - HALF_W;

  logic [2*HALF_W-1:0]      ll_r, ll_nxt;
  logic [HI_W+HALF_W-1:0]   m1_r, m1_nxt;
  logic [HI_W+HALF_W-1:0]   m2_r, m2_nxt;
  logic [2*HI_W-1:0]        hh_r, hh_nxt;
  logic [PROD_W-1:0]        sum_w;
  tau_fix_t                 p_r, p_nxt;

  always_comb begin
    ll_nxt = (2*HALF_W)'(a_i[HALF_W-1:0]) * (2*HALF_W)'(b_i[HALF_W-1:0]);
    m1_nxt = (HI_W+HALF_W)'(a_i[E_W-1:HALF_W]) * (HI_W+HALF_W)'(b_i[HALF_W-1:0]);
    m2_nxt = (HI_W+HALF_W)'(a_i[HALF_W-1:0]) * (HI_W+HALF_W)'(b_i[E_W-1:HALF_W]);
    hh_nxt = (2*HI_W)'(a_i[E_W-1:HALF_W]) * (2*HI_W)'(b_i[E_W-1:HALF_W]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      hh_r <= hh_nxt;
    end
  end

  always_comb begin
    sum_w = PROD_W'({hh_r, {(2*HALF_W){1'b0}}})
          + PROD_W'({m1_r, {HALF_W{1'b0}}})
          + PROD_W'({m2_r, {HALF_W{1'b0}}})
          + PROD_W'(ll_r);
    p_nxt = sum_w[FRAC_W+E_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

### hw/rtl/tau_exp.sv
// e = exp(-2|x|): one conditional multiply by a constant power per magnitude bit.
module tau_exp import tau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  tau_side_t side_i,
  output tau_side_t side_o,
  output tau_fix_t  e_o
);

  tau_side_t side_s [EXP_STEPS+1];
  tau_fix_t  e_s    [EXP_STEPS+1];

  assign side_s[0] = side_i;
  assign e_s[0]    = Q62_ONE;

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_step
    tau_side_t side_d1_r, side_d2_r;
    tau_fix_t  e_d1_r, e_d2_r;
    tau_fix_t  prod_w;

    tau_mul u_mul (
      .clk (clk),
      .en  (en),
      .a_i (e_s[k]),
      .b_i (BASE_TAB[k]),
      .p_o (prod_w)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_d1_r <= '0;
        side_d2_r <= '0;
      end else if (en) begin
        side_d1_r <= side_s[k];
        side_d2_r <= side_d1_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_d1_r <= e_s[k];
        e_d2_r <= e_d1_r;
      end
    end

    assign side_s[k+1] = side_d2_r;
    assign e_s[k+1]    = side_d2_r.mag[k] ? prod_w : e_d2_r;
  end

  assign side_o = side_s[EXP_STEPS];
  assign e_o    = e_s[EXP_STEPS];

endmodule

### hw/rtl/tau_div.sv
// p = floor(e * 2^62 / (1 + e)), restoring division, two quotient bits per stage.
module tau_div import tau_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  tau_side_t      side_i,
  input  tau_fix_t       e_i,
  output tau_side_t      side_o,
  output logic [Q_W-1:0] q_o
);

  tau_side_t      side_s [DIV_STAGES+1];
  logic [R_W-1:0] rem_s  [DIV_STAGES+1];
  logic [R_W-1:0] den_s  [DIV_STAGES+1];
  logic [Q_W-1:0] quo_s  [DIV_STAGES+1];

  assign side_s[0] = side_i;
  assign rem_s[0]  = R_W'(e_i);
  assign den_s[0]  = R_W'(Q62_ONE) + R_W'(e_i);
  assign quo_s[0]  = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    tau_side_t      side_r;
    logic [R_W-1:0] rem_r, rem_nxt;
    logic [R_W-1:0] den_r;
    logic [Q_W-1:0] quo_r, quo_nxt;

    always_comb begin
      rem_nxt = rem_s[s];
      quo_nxt = quo_s[s];
      for (int i = 0; i < DIV_PER_STAGE; i++) begin
        rem_nxt = {rem_nxt[R_W-2:0], 1'b0};
        if (rem_nxt >= den_s[s]) begin
          rem_nxt = rem_nxt - den_s[s];
          quo_nxt = {quo_nxt[Q_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r <= '0;
      end else if (en) begin
        side_r <= side_s[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        den_r <= den_s[s];
        quo_r <= quo_nxt;
      end
    end

    assign side_s[s+1] = side_r;
    assign rem_s[s+1]  = rem_r;
    assign den_s[s+1]  = den_r;
    assign quo_s[s+1]  = quo_r;
  end

  assign side_o = side_s[DIV_STAGES];
  assign q_o    = quo_s[DIV_STAGES];

endmodule

### hw/rtl/tau_post.sv
// tanh = 1 - 2p, derivative = 4p(1-p); round to Q1.14 and restore sign.
module tau_post import tau_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                deriv_mode,
  input  tau_side_t           side_i,
  input  logic [Q_W-1:0]      q_i,
  output logic                vld_o,
  output logic [RESULT_W-1:0] result_o
);

  tau_fix_t                 a_w, b_w, m_w;
  tau_side_t                side_d1_r, side_d2_r;
  logic [Q_W-1:0]           q_d1_r, q_d2_r;
  tau_fix_t                 v_w, rnd_w;
  logic [RESULT_W-2:0]      mag_w;

  assign a_w = E_W'(q_i);
  assign b_w = Q62_ONE - E_W'(q_i);

  tau_mul u_mul (
    .clk (clk),
    .en  (en),
    .a_i (a_w),
    .b_i (b_w),
    .p_o (m_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_d1_r <= '0;
      side_d2_r <= '0;
    end else if (en) begin
      side_d1_r <= side_i;
      side_d2_r <= side_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_d1_r <= q_i;
      q_d2_r <= q_d1_r;
    end
  end

  // p(1-p) <= 1/4, so the product's top two bits are clear
  always_comb begin
    if (deriv_mode) begin
      v_w = {m_w[E_W-3:0], 2'b00};
    end else begin
      v_w = Q62_ONE - {q_d2_r, 1'b0};
    end
    rnd_w = v_w + ROUND_BIAS;
    mag_w = rnd_w[E_W-1:ROUND_POS];
    if (!deriv_mode && side_d2_r.neg) begin
      result_o = RESULT_W'(0) - {1'b0, mag_w};
    end else begin
      result_o = {1'b0, mag_w};
    end
  end

  assign vld_o = side_d2_r.vld;

endmodule

### hw/rtl/tanh_activation_unit_top.sv
// Tanh activation unit.
// Input channel: in_valid / in_stall with in_sample_in, signed Q4.12.
// Result channel: out_valid / out_stall with out_result_out, signed Q1.14.
// A transaction completes on a rising edge with valid high and stall low.
// cfg_we writes cfg_derivative_mode: 0 gives tanh(x), 1 gives 1 - tanh(x)^2.
// Change it only while no transaction is in flight.
// Throughput: one sample per cycle, fully pipelined, while out_stall does not hold the pipeline.
// Pipeline: the input register, the exp chain (16 constant multiplies, two
// stages each), the 31-stage restoring divider, the two-stage derivative
// multiply and the output register.
// Reset (rst_n low, synchronous) empties the pipeline and selects tanh.
// While out_valid is held off by out_stall the whole pipeline freezes and
// in_stall is raised; nothing is dropped or repeated.
`include "tanh_activation_unit_top_defines.svh"

module tanh_activation_unit_top import tau_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] out_result_out,
  input  logic                       cfg_we,
  input  logic                       cfg_derivative_mode
);

  logic                deriv_mode_r;
  logic                ready_w;
  logic [MAG_W-1:0]    raw_w;
  tau_side_t           side_in_r, side_in_nxt;
  tau_side_t           exp_side_w, div_side_w;
  tau_fix_t            exp_e_w;
  logic [Q_W-1:0]      div_q_w;
  logic                post_vld_w;
  logic [RESULT_W-1:0] post_result_w;
  logic                out_valid_r;
  logic [RESULT_W-1:0] out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deriv_mode_r <= 1'b0;
    end else if (cfg_we) begin
      deriv_mode_r <= cfg_derivative_mode;
    end
  end

  assign ready_w  = !out_valid_r || !out_stall;
  assign in_stall = !ready_w;

  always_comb begin
    raw_w           = in_sample_in;
    side_in_nxt.vld = in_valid;
    side_in_nxt.neg = raw_w[MAG_W-1];
    side_in_nxt.mag = raw_w[MAG_W-1] ? (MAG_W'(0) - raw_w) : raw_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_in_r <= '0;
    end else if (ready_w) begin
      side_in_r <= side_in_nxt;
    end
  end

  tau_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (ready_w),
    .side_i (side_in_r),
    .side_o (exp_side_w),
    .e_o    (exp_e_w)
  );

  tau_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (ready_w),
    .side_i (exp_side_w),
    .e_i    (exp_e_w),
    .side_o (div_side_w),
    .q_o    (div_q_w)
  );

  tau_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (ready_w),
    .deriv_mode (deriv_mode_r),
    .side_i     (div_side_w),
    .q_i        (div_q_w),
    .vld_o      (post_vld_w),
    .result_o   (post_result_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_w) begin
      out_valid_r <= post_vld_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_w) begin
      out_result_r <= post_result_w;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_out = $signed(out_result_r);

  `TAU_ASSERT_NEXT(a_in_capture, in_valid && !in_stall, side_in_r.vld)
  `TAU_ASSERT_IMPL(a_deriv_nonneg, out_valid && deriv_mode_r, !out_result_out[RESULT_W-1])
  `TAU_ASSERT_IMPL(a_result_range, out_valid, (out_result_out <= RESULT_MAX) && (out_result_out >= -RESULT_MAX))

endmodule

### tb/sv/tb_tanh_activation_unit_top.sv
`timescale 1ns / 100ps

module tb_tanh_activation_unit_top;
  import tau_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 10;
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  typedef enum logic {
    MODE_TANH  = 1'b0,
    MODE_DERIV = 1'b1
  } act_mode_t;

  typedef struct packed {
    act_mode_t                  mode;
    logic [SAMPLE_W-1:0]        sample;
    logic                       typed;
    logic signed [RESULT_W-1:0] result;
  } dir_row_t;

  typedef struct packed {
    act_mode_t                  mode;
    logic [SAMPLE_W-1:0]        sample;
    logic signed [RESULT_W-1:0] result;
  } act_txn_t;

  // typed results only where they are obvious: zero and saturation
  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{MODE_TANH,  16'h0000, 1'b1, 16'sd0},
    '{MODE_TANH,  16'h8000, 1'b1, -16'sd16384},
    '{MODE_TANH,  16'h7FFF, 1'b1, 16'sd16384},
    '{MODE_TANH,  16'h0001, 1'b0, 16'sd0},
    '{MODE_TANH,  16'hFFFF, 1'b0, 16'sd0},
    '{MODE_TANH,  16'h1000, 1'b0, 16'sd0},
    '{MODE_TANH,  16'hF000, 1'b0, 16'sd0},
    '{MODE_TANH,  16'h0800, 1'b0, 16'sd0},
    '{MODE_TANH,  16'h5555, 1'b0, 16'sd0},
    '{MODE_TANH,  16'hAAAA, 1'b0, 16'sd0},
    '{MODE_TANH,  16'h0400, 1'b0, 16'sd0},
    '{MODE_DERIV, 16'h0000, 1'b1, 16'sd16384},
    '{MODE_DERIV, 16'h8000, 1'b1, 16'sd0},
    '{MODE_DERIV, 16'h7FFF, 1'b1, 16'sd0},
    '{MODE_DERIV, 16'h0001, 1'b0, 16'sd0},
    '{MODE_DERIV, 16'hFFFF, 1'b0, 16'sd0},
    '{MODE_DERIV, 16'h1000, 1'b0, 16'sd0},
    '{MODE_DERIV, 16'hF000, 1'b0, 16'sd0},
    '{MODE_DERIV, 16'h2AAA, 1'b0, 16'sd0},
    '{MODE_DERIV, 16'hD555, 1'b0, 16'sd0},
    '{MODE_TANH,  16'hC000, 1'b0, 16'sd0},
    '{MODE_TANH,  16'h3000, 1'b0, 16'sd0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [RESULT_W-1:0] out_result_out;
  logic                       cfg_we = 1'b0;
  logic                       cfg_derivative_mode = 1'b0;

  act_mode_t cur_mode = MODE_TANH;
  act_txn_t  pending_results[$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;

  tanh_activation_unit_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_in        (in_sample_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_out      (out_result_out),
    .cfg_we              (cfg_we),
    .cfg_derivative_mode (cfg_derivative_mode)
  );

  always #5 clk = ~clk;

  // (a*b) >> 62, truncated to 64 bits
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // exp(-1/2048) from six Taylor terms
  function automatic logic [63:0] exp_step_q62();
    logic [63:0] term;
    logic [63:0] sum;
    int          k;
    term = ONE_Q62;
    sum  = ONE_Q62;
    for (k = 1; k <= 6; k++) begin
      term = (term >> 11) / 64'(k);
      sum  = k[0] ? sum - term : sum + term;
    end
    return sum;
  endfunction

  // floor(n * 2^62 / d), restoring
  function automatic logic [63:0] q62_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    q = '0;
    r = n;
    for (i = 0; i < 62; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh or 1 - tanh^2 of a Q4.12 sample, as Q1.14 rounded to nearest
  function automatic logic signed [RESULT_W-1:0] tanh_q14(input logic [SAMPLE_W-1:0] x,
                                                          input act_mode_t mode);
    logic        neg;
    logic [16:0] mag;
    logic [63:0] e;
    logic [63:0] base;
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    int          b;
    neg  = x[SAMPLE_W-1];
    mag  = neg ? 17'h10000 - {1'b0, x} : {1'b0, x};
    e    = ONE_Q62;
    base = exp_step_q62();
    for (b = 0; b < 16; b++) begin
      if (mag[b]) e = q62_mul(e, base);
      base = q62_mul(base, base);
    end
    p = q62_div(e, ONE_Q62 + e);   // exp(-2|x|) / (1 + exp(-2|x|))
    if (mode == MODE_DERIV) v = q62_mul(p, ONE_Q62 - p) << 2;
    else v = ONE_Q62 - (p << 1);
    r = (v + (64'd1 << 47)) >> 48;
    if (mode == MODE_TANH && neg) r = -r;
    return r[RESULT_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int                  sel;
    logic [16:0]         mag;
    logic [SAMPLE_W-1:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      v = SAMPLE_W'($urandom);
    end else if (sel < 8) begin
      // -2.0 .. 2.0, where the curve bends
      v = SAMPLE_W'($urandom_range(0, 16383)) - 16'd8192;
    end else if (sel == 8) begin
      mag = 17'($urandom_range(20000, 32768));
      v = $urandom_range(0, 1) ? mag[15:0] : 16'(-mag);
    end else begin
      case ($urandom_range(0, 4))
        0:       v = 16'h0000;
        1:       v = 16'h8000;
        2:       v = 16'h7FFF;
        3:       v = 16'hFFFF;
        default: v = 16'h0001;
      endcase
    end
    return v;
  endfunction

  task automatic write_mode(input act_mode_t m);
    cfg_we              <= 1'b1;
    cfg_derivative_mode <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = m;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic typed,
                             input logic signed [RESULT_W-1:0] typed_val);
    act_txn_t txn;
    int       gap;
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    txn.mode   = cur_mode;
    txn.sample = x;
    txn.result = typed ? typed_val : tanh_q14(x, cur_mode);
    pending_results.push_back(txn);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // valid only drops when a real gap follows
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : rx_stall_gen
    int kind;
    int run;
    wait (rst_n == 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        kind = $urandom_range(0, 3);
        run  = $urandom_range(1, 40);
        repeat (run) begin
          case (kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    act_txn_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected transaction, result %0d", $time, out_result_out);
      end else begin
        want = pending_results.pop_front();
        if (out_result_out !== want.result) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mode %0d sample %h: expected %0d, got %0d", $time,
                     want.mode, want.sample, want.result, out_result_out);
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    int p;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_TANH);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].mode != cur_mode) begin
        drain();
        write_mode(DIR_TAB[i].mode);
      end
      send_sample(DIR_TAB[i].sample, DIR_TAB[i].typed, DIR_TAB[i].result);
    end

    for (p = 0; p < 8; p++) begin
      drain();
      write_mode(p[0] ? MODE_DERIV : MODE_TANH);
      // long output hold-off while the sender keeps pushing
      if (p == 1) hold_req = 1'b1;
      n = (p == 1) ? 200 : $urandom_range(50, 100);
      repeat (n) send_sample(pick_sample(), 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
